[rtl/ptgp_pkg.sv]
// Shared types, action codes and fixed-point helpers for Pauli term gate propagation.
`default_nettype none
package ptgp_pkg;

   localparam int MASK_BITS   = 64;
   localparam int QIDX_BITS   = 6;
   localparam int W_BITS      = 32;   // weight width, Q4.28
   localparam int F_BITS      = 32;   // factor width, Q1.30
   localparam int FRAC_SHIFT  = 30;
   localparam int PROD_BITS   = W_BITS + F_BITS;
   localparam int ACT_BITS    = 3;

   localparam logic [ACT_BITS-1:0] ACT_H    = 3'd0;
   localparam logic [ACT_BITS-1:0] ACT_S    = 3'd1;
   localparam logic [ACT_BITS-1:0] ACT_CNOT = 3'd2;
   localparam logic [ACT_BITS-1:0] ACT_RZ   = 3'd3;
   localparam logic [ACT_BITS-1:0] ACT_DEP  = 3'd4;

   typedef struct packed {
      logic [ACT_BITS-1:0]     action;
      logic [MASK_BITS-1:0]    x_bits;
      logic [MASK_BITS-1:0]    z_bits;
      logic signed [W_BITS-1:0] term_weight;
      logic [QIDX_BITS-1:0]    qubit_a;
      logic [QIDX_BITS-1:0]    qubit_b;
      logic signed [F_BITS-1:0] cos_val;
      logic signed [F_BITS-1:0] sin_val;
      logic signed [F_BITS-1:0] keep_factor;
   } req_type;

   typedef struct packed {
      logic [MASK_BITS-1:0]    out_x_bits;
      logic [MASK_BITS-1:0]    out_z_bits;
      logic signed [W_BITS-1:0] out_weight;
      logic                    last_of_item;
   } rsp_type;

   // One lane of the weight multiply: magnitudes plus the final sign.
   typedef struct packed {
      logic [W_BITS-1:0] w_mag;
      logic [F_BITS-1:0] f_mag;
      logic              neg;
   } mul_op_type;

   // Magnitude of a two's complement value; the most negative value maps to 2^(n-1).
   function automatic logic [W_BITS-1:0] mag_of(input logic [W_BITS-1:0] v);
      return v[W_BITS-1] ? (~v + W_BITS'(1)) : v;
   endfunction

endpackage
`default_nettype wire

[rtl/ptgp_fixmul.sv]
// Two-stage weight multiply: magnitude product, then round, sign and saturate.
`default_nettype none
module ptgp_fixmul (
   input  wire logic                           clock,
   input  wire logic                           en_prod,
   input  wire logic                           en_out,
   input  wire ptgp_pkg::mul_op_type           op,
   output logic signed [ptgp_pkg::W_BITS-1:0]  weight
);

   localparam int RMAG_BITS = ptgp_pkg::PROD_BITS - ptgp_pkg::FRAC_SHIFT;
   localparam logic [ptgp_pkg::PROD_BITS-1:0] HALF_LSB =
      ptgp_pkg::PROD_BITS'(1) << (ptgp_pkg::FRAC_SHIFT - 1);
   localparam logic [RMAG_BITS-1:0] POS_MAX =
      (RMAG_BITS'(1) << (ptgp_pkg::W_BITS - 1)) - RMAG_BITS'(1);
   localparam logic [RMAG_BITS-1:0] NEG_MAX = RMAG_BITS'(1) << (ptgp_pkg::W_BITS - 1);

   logic [ptgp_pkg::PROD_BITS-1:0] prod_ff;
   logic                           neg_ff;
   logic [ptgp_pkg::PROD_BITS-1:0] rnd_in;
   logic [RMAG_BITS-1:0]           rmag_in;
   logic [RMAG_BITS-1:0]           sat_in;
   logic [ptgp_pkg::W_BITS-1:0]    mag_in;
   logic [ptgp_pkg::W_BITS-1:0]    weight_in;
   logic [ptgp_pkg::W_BITS-1:0]    weight_ff;

   always_ff @(posedge clock) begin
      if (en_prod) begin
         prod_ff <= ptgp_pkg::PROD_BITS'(op.w_mag) * ptgp_pkg::PROD_BITS'(op.f_mag);
         neg_ff  <= op.neg;
      end
   end

   // round half away from zero on the magnitude
   always_comb begin
      rnd_in  = prod_ff + HALF_LSB;
      rmag_in = rnd_in[ptgp_pkg::PROD_BITS-1:ptgp_pkg::FRAC_SHIFT];
      if (neg_ff) begin
         sat_in = (rmag_in > NEG_MAX) ? NEG_MAX : rmag_in;
      end else begin
         sat_in = (rmag_in > POS_MAX) ? POS_MAX : rmag_in;
      end
      mag_in    = sat_in[ptgp_pkg::W_BITS-1:0];
      weight_in = neg_ff ? (~mag_in + ptgp_pkg::W_BITS'(1)) : mag_in;
   end

   always_ff @(posedge clock) begin
      if (en_out) begin
         weight_ff <= weight_in;
      end
   end

   assign weight = weight_ff;

endmodule
`default_nettype wire

[rtl/pauli_term_gate_propagation.sv]
// Top level: Pauli term conjugation by H, S, CNOT, RZ and depolarizing gates.
//
// Usage
//   req_*  : one request = a weighted Pauli term (x/z masks, Q4.28 weight) plus
//            one gate and its factors. Taken when req_valid && req_ready.
//   rsp_*  : one or two results per request; last_of_item marks the final one.
//            RZ on a qubit carrying X or Y gives two results (cos term, then the
//            sin term), everything else gives one.
//   Throughput: one request per cycle for single-result gates while rsp_ready is
//            high; a two-result RZ holds the output register until both results
//            are taken, so the next request waits behind the sin result.
//   Pipeline: skid -> decode -> multiply -> round/saturate -> output register.
//            Every weight goes through the multiplier (pass-through uses 1.0).
//   Stall: rsp_ready low freezes the output register and backs the pipeline up
//            stage by stage; req_ready is registered (skid buffer) and drops
//            only once the skid entry is full. Nothing is dropped or repeated.
//   Reset: synchronous, active high; clears all valid bits and the output phase, no other state.
`default_nettype none
module pauli_term_gate_propagation #(
   parameter int QUBIT_COUNT = 64
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire ptgp_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output ptgp_pkg::rsp_type      rsp_data
);

   localparam int QCMP_BITS = ptgp_pkg::QIDX_BITS + 1;
   localparam logic [QCMP_BITS-1:0] QUBIT_LIMIT = QCMP_BITS'(QUBIT_COUNT);
   localparam logic [ptgp_pkg::F_BITS-1:0] UNITY =
      ptgp_pkg::F_BITS'(1) << ptgp_pkg::FRAC_SHIFT;

   // masks and the two-result flag that ride alongside the weight lanes
   typedef struct packed {
      logic [ptgp_pkg::MASK_BITS-1:0] x;
      logic [ptgp_pkg::MASK_BITS-1:0] z0;
      logic [ptgp_pkg::MASK_BITS-1:0] z1;
      logic                           two;
   } side_type;

   // ---------------- input skid ----------------
   logic              skid_valid_ff;
   ptgp_pkg::req_type skid_data_ff;
   logic              src_valid;
   ptgp_pkg::req_type src;
   logic              req_fire;

   // per-stage ready chain
   logic r1, r2, r3, out_load;

   assign req_ready = !skid_valid_ff;
   assign req_fire  = req_valid && req_ready;
   assign src_valid = skid_valid_ff || req_valid;
   assign src       = skid_valid_ff ? skid_data_ff : req_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (r1) skid_valid_ff <= 1'b0;
      end else if (req_fire && !r1) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!skid_valid_ff && req_fire && !r1) begin
         skid_data_ff <= req_data;
      end
   end

   // ---------------- stage 1: decode ----------------
   side_type             dec_side_in;
   ptgp_pkg::mul_op_type op0_in, op1_in;

   always_comb begin
      logic [ptgp_pkg::MASK_BITS-1:0] ma, mb;
      logic                           xa, za, xb, zb, qa_ok, qb_ok;
      logic                           w_neg, flip0;
      logic [ptgp_pkg::W_BITS-1:0]    w_mag;
      logic [ptgp_pkg::F_BITS-1:0]    f0_mag;
      logic                           f0_neg;

      ma    = ptgp_pkg::MASK_BITS'(1) << src.qubit_a;
      mb    = ptgp_pkg::MASK_BITS'(1) << src.qubit_b;
      xa    = src.x_bits[src.qubit_a];
      za    = src.z_bits[src.qubit_a];
      xb    = src.x_bits[src.qubit_b];
      zb    = src.z_bits[src.qubit_b];
      qa_ok = {1'b0, src.qubit_a} < QUBIT_LIMIT;
      qb_ok = {1'b0, src.qubit_b} < QUBIT_LIMIT;
      w_neg = src.term_weight[ptgp_pkg::W_BITS-1];
      w_mag = ptgp_pkg::mag_of(src.term_weight);

      dec_side_in.x   = src.x_bits;
      dec_side_in.z0  = src.z_bits;
      dec_side_in.z1  = src.z_bits ^ ma;
      dec_side_in.two = 1'b0;
      flip0  = 1'b0;
      f0_mag = UNITY;
      f0_neg = 1'b0;

      if (qa_ok) begin
         case (src.action)
            ptgp_pkg::ACT_H: begin
               if (xa != za) begin
                  dec_side_in.x  = src.x_bits ^ ma;
                  dec_side_in.z0 = src.z_bits ^ ma;
               end else if (xa && za) begin
                  flip0 = 1'b1;
               end
            end
            ptgp_pkg::ACT_S: begin
               if (xa) begin
                  dec_side_in.z0 = src.z_bits ^ ma;
                  flip0 = !za;
               end
            end
            ptgp_pkg::ACT_CNOT: begin
               if (qb_ok && (src.qubit_a != src.qubit_b)) begin
                  if (xa) dec_side_in.x  = src.x_bits ^ mb;
                  if (zb) dec_side_in.z0 = src.z_bits ^ ma;
                  flip0 = xa && zb && (xb == za);
               end
            end
            ptgp_pkg::ACT_RZ: begin
               if (xa) begin
                  dec_side_in.two = 1'b1;
                  f0_mag = ptgp_pkg::mag_of(src.cos_val);
                  f0_neg = src.cos_val[ptgp_pkg::F_BITS-1];
               end
            end
            ptgp_pkg::ACT_DEP: begin
               if (xa || za) begin
                  f0_mag = ptgp_pkg::mag_of(src.keep_factor);
                  f0_neg = src.keep_factor[ptgp_pkg::F_BITS-1];
               end
            end
            default: begin
               // unknown gate: pass through
            end
         endcase
      end

      op0_in.w_mag = w_mag;
      op0_in.f_mag = f0_mag;
      op0_in.neg   = w_neg ^ f0_neg ^ flip0;
      // sin lane: X picks up -sin, Y picks up +sin
      op1_in.w_mag = w_mag;
      op1_in.f_mag = ptgp_pkg::mag_of(src.sin_val);
      op1_in.neg   = w_neg ^ src.sin_val[ptgp_pkg::F_BITS-1] ^ !za;
   end

   logic                 s1_valid_ff, s2_valid_ff, s3_valid_ff;
   side_type             s1_side_ff, s2_side_ff, s3_side_ff;
   ptgp_pkg::mul_op_type op0_ff, op1_ff;

   // ---------------- output register ----------------
   logic                           o_valid_ff, o_phase_ff;
   side_type                       o_side_ff;
   logic [ptgp_pkg::W_BITS-1:0]    o_w0_ff, o_w1_ff;
   logic [ptgp_pkg::W_BITS-1:0]    w0, w1;
   logic                           o_last;

   assign o_last   = !o_side_ff.two || o_phase_ff;
   assign out_load = !o_valid_ff || (rsp_ready && o_last);
   assign r3       = !s3_valid_ff || out_load;
   assign r2       = !s2_valid_ff || r3;
   assign r1       = !s1_valid_ff || r2;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         if (r1) s1_valid_ff <= src_valid;
         if (r2) s2_valid_ff <= s1_valid_ff;
         if (r3) s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (r1) begin
         s1_side_ff <= dec_side_in;
         op0_ff     <= op0_in;
         op1_ff     <= op1_in;
      end
      if (r2) s2_side_ff <= s1_side_ff;
      if (r3) s3_side_ff <= s2_side_ff;
   end

   // ---------------- stages 2 and 3: weight lanes ----------------
   ptgp_fixmul u_lane_cos (
      .clock   (clock),
      .en_prod (r2),
      .en_out  (r3),
      .op      (op0_ff),
      .weight  (w0)
   );

   ptgp_fixmul u_lane_sin (
      .clock   (clock),
      .en_prod (r2),
      .en_out  (r3),
      .op      (op1_ff),
      .weight  (w1)
   );

   // ---------------- result expansion ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         o_valid_ff <= 1'b0;
         o_phase_ff <= 1'b0;
      end else if (out_load) begin
         o_valid_ff <= s3_valid_ff;
         o_phase_ff <= 1'b0;
      end else if (rsp_ready) begin
         // first of two results taken, show the second
         o_phase_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         o_side_ff <= s3_side_ff;
         o_w0_ff   <= w0;
         o_w1_ff   <= w1;
      end
   end

   assign rsp_valid              = o_valid_ff;
   assign rsp_data.out_x_bits    = o_side_ff.x;
   assign rsp_data.out_z_bits    = o_phase_ff ? o_side_ff.z1 : o_side_ff.z0;
   assign rsp_data.out_weight    = o_phase_ff ? o_w1_ff : o_w0_ff;
   assign rsp_data.last_of_item  = o_last;

endmodule
`default_nettype wire
